>>> rtl/efc_pkg.sv
// efc_pkg: verdict codes, unreachable codes, register map and field widths
// for the ipv4/arp receive frame classifier; no dependencies
package efc_pkg;

    // verdict codes of one classified frame
    typedef enum logic [2:0] {
        VERDICT_IGNORE  = 3'd0,
        VERDICT_ARP_REQ = 3'd1,
        VERDICT_ARP_REP = 3'd2,
        VERDICT_ECHO    = 3'd3,
        VERDICT_UDP     = 3'd4,
        VERDICT_UNREACH = 3'd5
    } t_verdict;

    // icmp destination unreachable codes
    localparam logic [3:0] UNR_NONE     = 4'd0;
    localparam logic [3:0] UNR_PROTOCOL = 4'd2;
    localparam logic [3:0] UNR_PORT     = 4'd3;
    localparam logic [3:0] UNR_FRAGMENT = 4'd4;
    localparam logic [3:0] UNR_FILTERED = 4'd13;

    // configuration register map, word index = paddr[4:2]
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_IP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_D   = 3'd6;

    localparam int unsigned NUM_PORT_REGS = 4;

    // protocol constants, words captured first byte low
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0608;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0008;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0100;
    localparam logic [15:0] ARP_OP_REP    = 16'h0200;
    localparam logic [15:0] FRAG_MASK     = 16'hffbf;
    localparam logic [31:0] IP_BROADCAST  = 32'hffffffff;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
    localparam logic [15:0] IP_HDR_LEN    = 16'd20;

endpackage

>>> rtl/efc_rx_if.sv
// efc_rx_if: receive byte stream channel, valid/ready plus frame byte
// depends on nothing
interface efc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> rtl/efc_res_if.sv
// efc_res_if: classification result channel, valid/ready plus verdict fields
// depends on efc_pkg
interface efc_res_if;
    import efc_pkg::*;

    logic        valid;
    logic        ready;
    t_verdict    verdict;
    logic [3:0]  unreach_code;
    logic [1:0]  port_slot;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [15:0] ip_total_len;

    modport source (output valid, output verdict, output unreach_code, output port_slot,
                    output peer_mac, output peer_ip, output ip_total_len, input ready);
    modport sink   (input valid, input verdict, input unreach_code, input port_slot,
                    input peer_mac, input peer_ip, input ip_total_len, output ready);
endinterface

>>> rtl/ethernet_ipv4_arp_frame_classifier_core.sv
// ethernet_ipv4_arp_frame_classifier_core: receive classifier for arp/ipv4 frames
// depends on efc_pkg, efc_rx_if, efc_res_if
//
//   channel   direction  handshake            payload
//   i_rx      in         valid/ready          frame_byte, last_byte
//   o_res     out        valid/ready          verdict, unreach_code, port_slot,
//                                             peer_mac, peer_ip, ip_total_len
//   apb       in         psel/penable/pready  paddr, pwdata, prdata (7 words)
//
// one byte transfer per cycle sustained while o_res is not stalled; after the last
// byte is taken the result goes through field capture, then the result register
// synchronous active-low reset clears config, frame fields and all valids
// a stalled result holds the classify stage; the input register and the
// capture stage keep taking bytes until the stall reaches them
module ethernet_ipv4_arp_frame_classifier_core #(
    parameter int unsigned PORT_SLOTS = 4,
    parameter int unsigned MAX_FRAME  = 1536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    efc_rx_if.sink                           i_rx,
    efc_res_if.source                        o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [efc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import efc_pkg::*;

    // byte index saturates at MAX_FRAME, frame length is index plus one
    localparam int unsigned IDX_W = $clog2(MAX_FRAME + 1);
    localparam int unsigned LEN_W = $clog2(MAX_FRAME + 2);

    // ---------------- configuration registers ----------------
    logic [31:0] r_own_ip;
    logic [31:0] r_query_ip;
    logic        r_query_on;
    logic [15:0] r_udp_port [NUM_PORT_REGS];

    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip   <= '0;
            r_query_ip <= '0;
            r_query_on <= 1'b0;
            for (int k = 0; k < NUM_PORT_REGS; k++) begin
                r_udp_port[k] <= '0;
            end
        end else if (cfg_wr) begin
            // writes past the last register fall through and are dropped
            unique case (cfg_idx)
                CFG_OWN_IP:   r_own_ip      <= pwdata;
                CFG_QUERY_IP: r_query_ip    <= pwdata;
                CFG_QUERY_ON: r_query_on    <= pwdata[0];
                CFG_PORT_A:   r_udp_port[0] <= pwdata[15:0];
                CFG_PORT_B:   r_udp_port[1] <= pwdata[15:0];
                CFG_PORT_C:   r_udp_port[2] <= pwdata[15:0];
                CFG_PORT_D:   r_udp_port[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_OWN_IP:   prdata = r_own_ip;
            CFG_QUERY_IP: prdata = r_query_ip;
            CFG_QUERY_ON: prdata = {31'd0, r_query_on};
            CFG_PORT_A:   prdata = {16'd0, r_udp_port[0]};
            CFG_PORT_B:   prdata = {16'd0, r_udp_port[1]};
            CFG_PORT_C:   prdata = {16'd0, r_udp_port[2]};
            CFG_PORT_D:   prdata = {16'd0, r_udp_port[3]};
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // stage 1: input register holding one byte transfer
    // stage 2: classify pending, frame fields complete in the capture registers
    // stage 3: result register driving o_res
    logic             r_s1_vld, n_s1_vld;
    logic [7:0]       r_s1_byte;
    logic             r_s1_last;
    logic             r_s2_vld, n_s2_vld;
    logic [LEN_W-1:0] r_s2_len;
    logic             r_out_vld, n_out_vld;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic rx_take;
    logic s1_adv;
    logic s2_fire;

    // the classify stage reads the capture registers, so capture waits for it;
    // a byte advancing alongside a firing classify is always at index zero
    assign s2_fire    = r_s2_vld && (!r_out_vld || o_res.ready);
    assign s1_adv     = r_s1_vld && (!r_s2_vld || s2_fire);
    assign i_rx.ready = !r_s1_vld || s1_adv;
    assign rx_take    = i_rx.valid && i_rx.ready;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (rx_take) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end

        n_s2_vld = r_s2_vld;
        if (s1_adv && r_s1_last) begin
            n_s2_vld = 1'b1;
        end else if (s2_fire) begin
            n_s2_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (s2_fire) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end

        n_idx = r_idx;
        if (s1_adv) begin
            if (r_s1_last) begin
                n_idx = '0;
            end else if (r_idx != IDX_W'(MAX_FRAME)) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= n_s2_vld;
            r_out_vld <= n_out_vld;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_s1_byte <= i_rx.frame_byte;
            r_s1_last <= i_rx.last_byte;
        end
        if (s1_adv && r_s1_last) begin
            r_s2_len <= LEN_W'(r_idx) + LEN_W'(1);
        end
    end

    // ---------------- field capture by byte offset ----------------
    // multi-byte words keep the first frame byte low, except total length,
    // udp port and udp length which are kept first byte high
    logic [15:0] r_eth_type,   n_eth_type;
    logic [47:0] r_src_mac,    n_src_mac;
    logic [15:0] r_frag_word,  n_frag_word;   // arp opcode shares bytes 20..21
    logic [47:0] r_arp_mac,    n_arp_mac;
    logic [31:0] r_arp_sip,    n_arp_sip;
    logic [31:0] r_arp_tip,    n_arp_tip;
    logic [7:0]  r_ver_ihl,    n_ver_ihl;
    logic [15:0] r_total_len,  n_total_len;
    logic [7:0]  r_proto,      n_proto;
    logic [31:0] r_src_ip,     n_src_ip;
    logic [31:0] r_dst_ip,     n_dst_ip;
    logic [19:0] r_hdr_sum,    n_hdr_sum;
    logic [7:0]  r_icmp_kind,  n_icmp_kind;
    logic [15:0] r_udp_dport,  n_udp_dport;
    logic [15:0] r_udp_len,    n_udp_len;

    always_comb begin
        n_eth_type  = r_eth_type;
        n_src_mac   = r_src_mac;
        n_frag_word = r_frag_word;
        n_arp_mac   = r_arp_mac;
        n_arp_sip   = r_arp_sip;
        n_arp_tip   = r_arp_tip;
        n_ver_ihl   = r_ver_ihl;
        n_total_len = r_total_len;
        n_proto     = r_proto;
        n_src_ip    = r_src_ip;
        n_dst_ip    = r_dst_ip;
        n_hdr_sum   = r_hdr_sum;
        n_icmp_kind = r_icmp_kind;
        n_udp_dport = r_udp_dport;
        n_udp_len   = r_udp_len;

        // per-frame state clears once the verdict moves into the result register
        if (s2_fire) begin
            n_eth_type  = '0;
            n_src_mac   = '0;
            n_frag_word = '0;
            n_arp_mac   = '0;
            n_arp_sip   = '0;
            n_arp_tip   = '0;
            n_ver_ihl   = '0;
            n_total_len = '0;
            n_proto     = '0;
            n_src_ip    = '0;
            n_dst_ip    = '0;
            n_hdr_sum   = '0;
            n_icmp_kind = '0;
            n_udp_dport = '0;
            n_udp_len   = '0;
        end

        if (s1_adv) begin
            for (int k = 0; k < 6; k++) begin
                if (r_idx == IDX_W'(6 + k))  n_src_mac[8*k +: 8] = r_s1_byte;
                if (r_idx == IDX_W'(22 + k)) n_arp_mac[8*k +: 8] = r_s1_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (r_idx == IDX_W'(26 + k)) n_src_ip[8*k +: 8]  = r_s1_byte;
                if (r_idx == IDX_W'(28 + k)) n_arp_sip[8*k +: 8] = r_s1_byte;
                if (r_idx == IDX_W'(30 + k)) n_dst_ip[8*k +: 8]  = r_s1_byte;
                if (r_idx == IDX_W'(38 + k)) n_arp_tip[8*k +: 8] = r_s1_byte;
            end
            if (r_idx == IDX_W'(12)) n_eth_type[7:0]   = r_s1_byte;
            if (r_idx == IDX_W'(13)) n_eth_type[15:8]  = r_s1_byte;
            if (r_idx == IDX_W'(14)) n_ver_ihl         = r_s1_byte;
            if (r_idx == IDX_W'(16)) n_total_len[15:8] = r_s1_byte;
            if (r_idx == IDX_W'(17)) n_total_len[7:0]  = r_s1_byte;
            if (r_idx == IDX_W'(20)) n_frag_word[7:0]  = r_s1_byte;
            if (r_idx == IDX_W'(21)) n_frag_word[15:8] = r_s1_byte;
            if (r_idx == IDX_W'(23)) n_proto           = r_s1_byte;
            if (r_idx == IDX_W'(34)) n_icmp_kind       = r_s1_byte;
            if (r_idx == IDX_W'(36)) n_udp_dport[15:8] = r_s1_byte;
            if (r_idx == IDX_W'(37)) n_udp_dport[7:0]  = r_s1_byte;
            if (r_idx == IDX_W'(38)) n_udp_len[15:8]   = r_s1_byte;
            if (r_idx == IDX_W'(39)) n_udp_len[7:0]    = r_s1_byte;
            // ip header bytes 14..33, odd offsets land in the high byte lane
            if (r_idx >= IDX_W'(14) && r_idx < IDX_W'(34)) begin
                if (r_idx[0]) begin
                    n_hdr_sum = r_hdr_sum + {4'd0, r_s1_byte, 8'd0};
                end else begin
                    n_hdr_sum = r_hdr_sum + {12'd0, r_s1_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eth_type  <= '0;
            r_src_mac   <= '0;
            r_frag_word <= '0;
            r_arp_mac   <= '0;
            r_arp_sip   <= '0;
            r_arp_tip   <= '0;
            r_ver_ihl   <= '0;
            r_total_len <= '0;
            r_proto     <= '0;
            r_src_ip    <= '0;
            r_dst_ip    <= '0;
            r_hdr_sum   <= '0;
            r_icmp_kind <= '0;
            r_udp_dport <= '0;
            r_udp_len   <= '0;
        end else begin
            r_eth_type  <= n_eth_type;
            r_src_mac   <= n_src_mac;
            r_frag_word <= n_frag_word;
            r_arp_mac   <= n_arp_mac;
            r_arp_sip   <= n_arp_sip;
            r_arp_tip   <= n_arp_tip;
            r_ver_ihl   <= n_ver_ihl;
            r_total_len <= n_total_len;
            r_proto     <= n_proto;
            r_src_ip    <= n_src_ip;
            r_dst_ip    <= n_dst_ip;
            r_hdr_sum   <= n_hdr_sum;
            r_icmp_kind <= n_icmp_kind;
            r_udp_dport <= n_udp_dport;
            r_udp_len   <= n_udp_len;
        end
    end

    // ---------------- classification ----------------
    t_verdict    cls_verdict;
    logic [3:0]  cls_code;
    logic [1:0]  cls_slot;
    logic [16:0] fold_a;
    logic [16:0] fold_b;
    logic        sum_ok;
    logic        is_bcast;
    logic        slot_hit;
    logic [1:0]  slot_sel;

    // end-around carry fold of the header sum, good when it folds to all ones
    assign fold_a   = {13'd0, r_hdr_sum[19:16]} + {1'b0, r_hdr_sum[15:0]};
    assign fold_b   = fold_a + {16'd0, fold_a[16]};
    assign sum_ok   = (~fold_b[15:0]) == 16'd0;
    assign is_bcast = r_dst_ip == IP_BROADCAST;

    // lowest enabled slot whose nonzero port matches wins
    always_comb begin
        slot_hit = 1'b0;
        slot_sel = 2'd0;
        for (int k = NUM_PORT_REGS - 1; k >= 0; k--) begin
            if (k < PORT_SLOTS && r_udp_port[k] != 16'd0 && r_udp_port[k] == r_udp_dport) begin
                slot_hit = 1'b1;
                slot_sel = 2'(k);
            end
        end
    end

    always_comb begin
        cls_verdict = VERDICT_IGNORE;
        cls_code    = UNR_NONE;
        cls_slot    = 2'd0;
        if (r_eth_type == ETH_TYPE_ARP) begin
            if (r_s2_len >= LEN_W'(42)) begin
                if (r_frag_word == ARP_OP_REP && r_query_on && r_arp_sip == r_query_ip) begin
                    cls_verdict = VERDICT_ARP_REP;
                end else if (r_frag_word == ARP_OP_REQ && r_arp_tip == r_own_ip) begin
                    cls_verdict = VERDICT_ARP_REQ;
                end
            end
        end else if (r_eth_type == ETH_TYPE_IPV4 && r_s2_len >= LEN_W'(34)
                     && r_ver_ihl[7:4] == 4'd4
                     && (r_dst_ip == r_own_ip || is_bcast)) begin
            if (r_ver_ihl[3:0] != 4'd5) begin
                cls_verdict = is_bcast ? VERDICT_IGNORE : VERDICT_UNREACH;
                cls_code    = is_bcast ? UNR_NONE : UNR_FILTERED;
            end else if (!sum_ok) begin
                cls_verdict = VERDICT_IGNORE;
            end else if ((r_frag_word & FRAG_MASK) != 16'd0) begin
                cls_verdict = is_bcast ? VERDICT_IGNORE : VERDICT_UNREACH;
                cls_code    = is_bcast ? UNR_NONE : UNR_FRAGMENT;
            end else if (r_proto == PROTO_ICMP) begin
                if (r_s2_len >= LEN_W'(35) && r_icmp_kind == ICMP_ECHO_REQ) begin
                    cls_verdict = VERDICT_ECHO;
                end
            end else if (r_proto != PROTO_UDP) begin
                cls_verdict = is_bcast ? VERDICT_IGNORE : VERDICT_UNREACH;
                cls_code    = is_bcast ? UNR_NONE : UNR_PROTOCOL;
            end else if (r_s2_len < LEN_W'(40)) begin
                cls_verdict = VERDICT_IGNORE;
            end else if (r_total_len >= IP_HDR_LEN && r_udp_len > r_total_len - IP_HDR_LEN) begin
                cls_verdict = VERDICT_IGNORE;
            end else if (slot_hit) begin
                cls_verdict = VERDICT_UDP;
                cls_slot    = slot_sel;
            end else begin
                cls_verdict = is_bcast ? VERDICT_IGNORE : VERDICT_UNREACH;
                cls_code    = is_bcast ? UNR_NONE : UNR_PORT;
            end
        end
    end

    // ---------------- result register ----------------
    t_verdict    r_verdict;
    logic [3:0]  r_code;
    logic [1:0]  r_slot;
    logic [47:0] r_peer_mac;
    logic [31:0] r_peer_ip;
    logic [15:0] r_ip_len;
    logic        cls_arp;
    logic        cls_ip;

    assign cls_arp = cls_verdict == VERDICT_ARP_REQ || cls_verdict == VERDICT_ARP_REP;
    assign cls_ip  = cls_verdict == VERDICT_ECHO || cls_verdict == VERDICT_UDP
                     || cls_verdict == VERDICT_UNREACH;

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_verdict  <= cls_verdict;
            r_code     <= cls_code;
            r_slot     <= cls_slot;
            r_peer_mac <= cls_arp ? r_arp_mac : r_src_mac;
            r_peer_ip  <= cls_arp ? r_arp_sip : (cls_ip ? r_src_ip : 32'd0);
            r_ip_len   <= cls_ip ? r_total_len : 16'd0;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.verdict      = r_verdict;
    assign o_res.unreach_code = r_code;
    assign o_res.port_slot    = r_slot;
    assign o_res.peer_mac     = r_peer_mac;
    assign o_res.peer_ip      = r_peer_ip;
    assign o_res.ip_total_len = r_ip_len;

endmodule

>>> rtl/efc_checker.sv
// efc_checker: port-level assertions for the frame classifier result channel
// depends on efc_pkg; bound to ethernet_ipv4_arp_frame_classifier_core
module efc_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input efc_pkg::t_verdict       i_verdict,
    input logic [3:0]              i_unreach_code,
    input logic [1:0]              i_port_slot,
    input logic [31:0]             i_peer_ip,
    input logic [15:0]             i_ip_total_len
);
    import efc_pkg::*;

    // a stalled result keeps its verdict, unreachable code, port slot and peer ip
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_verdict)
            && $stable(i_unreach_code) && $stable(i_port_slot) && $stable(i_peer_ip))
        else $error("result changed while stalled");

    // unreachable code only rides with an unreachable verdict
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict != VERDICT_UNREACH |-> i_unreach_code == UNR_NONE)
        else $error("unreachable code without unreachable verdict");

    // port slot only rides with a udp verdict
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict != VERDICT_UDP |-> i_port_slot == 2'd0)
        else $error("port slot without udp verdict");

    // an ignored frame reports no peer ip and no length
    a_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict == VERDICT_IGNORE |-> i_peer_ip == 32'd0
            && i_ip_total_len == 16'd0)
        else $error("ignored frame carries ip fields");

endmodule

bind ethernet_ipv4_arp_frame_classifier_core efc_checker u_efc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_verdict      (o_res.verdict),
    .i_unreach_code (o_res.unreach_code),
    .i_port_slot    (o_res.port_slot),
    .i_peer_ip      (o_res.peer_ip),
    .i_ip_total_len (o_res.ip_total_len)
);

>>> verif/testbench.sv
// testbench for ethernet_ipv4_arp_frame_classifier_core: random and directed arp/ipv4 frames
// are streamed in byte by byte and every verdict is checked against an in-bench predictor
// depends on efc_pkg, efc_rx_if, efc_res_if and the classifier core
module testbench;
    import efc_pkg::*;

    // small frame limit so that index saturation is reached with short frames
    localparam int unsigned PORT_SLOTS     = 4;
    localparam int unsigned MAX_FRAME      = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // frame flavors the generator knows how to build
    typedef enum int unsigned {
        FR_ARP_REQ,
        FR_ARP_REP,
        FR_ARP_OTHER,
        FR_ICMP,
        FR_UDP,
        FR_OTHER_PROTO,
        FR_NOISE
    } t_frame_kind;

    // flaws that can be injected into a frame, one bit each
    localparam int unsigned FL_VERSION   = 1 << 0;
    localparam int unsigned FL_IHL       = 1 << 1;
    localparam int unsigned FL_CSUM      = 1 << 2;
    localparam int unsigned FL_FRAG      = 1 << 3;
    localparam int unsigned FL_DST_BCAST = 1 << 4;
    localparam int unsigned FL_DST_OTHER = 1 << 5;
    localparam int unsigned FL_UDPLEN    = 1 << 6;
    localparam int unsigned FL_SHORTLEN  = 1 << 7;
    localparam int unsigned FL_TRUNC     = 1 << 8;
    localparam int unsigned FL_ICMP_TYPE = 1 << 9;
    localparam int unsigned FL_NOPORT    = 1 << 10;
    localparam int unsigned FL_LONG      = 1 << 11;
    localparam int unsigned NUM_RAND_FLAWS = 11;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rx_beat;

    typedef struct packed {
        t_verdict    verdict;
        logic [3:0]  unreach_code;
        logic [1:0]  port_slot;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [15:0] ip_total_len;
    } t_verdict_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    efc_rx_if  rx_ch ();
    efc_res_if res_ch ();

    ethernet_ipv4_arp_frame_classifier_core #(
        .PORT_SLOTS (PORT_SLOTS),
        .MAX_FRAME  (MAX_FRAME)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 time unit clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bench copy of the configuration registers
    logic [31:0] cfg_own_ip   = '0;
    logic [31:0] cfg_query_ip = '0;
    logic        cfg_query_on = 1'b0;
    logic [15:0] cfg_port [0:NUM_PORT_REGS-1] = '{default: '0};

    // predictor copy of the per-frame capture state
    logic [10:0] byte_idx   = '0;
    logic [15:0] eth_type_w = '0;
    logic [47:0] eth_src    = '0;
    logic [15:0] arp_op_w   = '0;
    logic [47:0] arp_sha    = '0;
    logic [31:0] arp_spa    = '0;
    logic [31:0] arp_tpa    = '0;
    logic [7:0]  ver_ihl    = '0;
    logic [15:0] tot_len    = '0;
    logic [15:0] frag_w     = '0;
    logic [7:0]  proto      = '0;
    logic [31:0] ip_src     = '0;
    logic [31:0] ip_dst     = '0;
    logic [19:0] hdr_sum    = '0;
    logic [7:0]  icmp_type  = '0;
    logic [15:0] udp_dport  = '0;
    logic [15:0] udp_len    = '0;

    t_rx_beat     rx_bytes_pending [$];
    t_verdict_rec expected_verdicts [$];

    logic [7:0]  frame_buf [0:1599];
    int          frame_len;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  rx_took       = 1'b0;
    int  stall_cycles  = 0;
    int  mismatches    = 0;

    // classification of a completed frame from the captured fields
    function automatic void judge_frame(input int unsigned len, output t_verdict v,
                                        output logic [3:0] code, output logic [1:0] slot);
        logic [16:0] s;
        s    = {1'b0, hdr_sum[15:0]} + 17'(hdr_sum[19:16]);
        s    = s + 17'(s[16]);
        v    = VERDICT_IGNORE;
        code = UNR_NONE;
        slot = 2'd0;
        if (eth_type_w == ETH_TYPE_ARP) begin
            if (len < 42) return;
            // a reply from the queried host wins over a request for our address
            if (arp_op_w == ARP_OP_REP && cfg_query_on && arp_spa == cfg_query_ip)
                v = VERDICT_ARP_REP;
            else if (arp_op_w == ARP_OP_REQ && arp_tpa == cfg_own_ip)
                v = VERDICT_ARP_REQ;
            return;
        end
        if (eth_type_w != ETH_TYPE_IPV4 || len < 34) return;
        if (ver_ihl[7:4] != 4'd4) return;
        if (ip_dst != cfg_own_ip && ip_dst != IP_BROADCAST) return;
        if (ver_ihl[3:0] != 4'd5) begin
            code = UNR_FILTERED;
        end else if (~s[15:0] != 16'd0) begin
            return;
        end else if ((frag_w & FRAG_MASK) != 16'd0) begin
            code = UNR_FRAGMENT;
        end else if (proto == PROTO_ICMP) begin
            if (len >= 35 && icmp_type == ICMP_ECHO_REQ) v = VERDICT_ECHO;
            return;
        end else if (proto != PROTO_UDP) begin
            code = UNR_PROTOCOL;
        end else if (len < 40) begin
            return;
        end else if (tot_len >= IP_HDR_LEN && int'(udp_len) > int'(tot_len) - 20) begin
            return;
        end else begin
            // lowest used slot with a matching port takes the datagram
            for (int k = 0; k < PORT_SLOTS && k < NUM_PORT_REGS; k++) begin
                if (cfg_port[k] != 16'd0 && cfg_port[k] == udp_dport) begin
                    v    = VERDICT_UDP;
                    slot = 2'(k);
                    return;
                end
            end
            code = UNR_PORT;
        end
        // no unreachable goes back toward a broadcast destination
        v = (ip_dst == IP_BROADCAST) ? VERDICT_IGNORE : VERDICT_UNREACH;
    endfunction

    // capture one accepted byte; on the last byte queue the expected verdict
    task automatic track_frame_byte(input logic [7:0] b, input logic last);
        logic [10:0]  i;
        t_verdict     v;
        logic [3:0]   code;
        logic [1:0]   slot;
        t_verdict_rec rec;
        i = byte_idx;
        if (i >= 6 && i < 12) eth_src[8*(i-6) +: 8] = b;
        if (i == 12 || i == 13) eth_type_w[8*(i-12) +: 8] = b;
        if (i >= 14 && i < 34) hdr_sum = hdr_sum + 20'(i[0] ? {b, 8'h00} : {8'h00, b});
        if (i == 14) ver_ihl = b;
        if (i == 16) tot_len[15:8] = b;
        if (i == 17) tot_len[7:0] = b;
        // fragment word and arp opcode share the same frame bytes
        if (i == 20 || i == 21) begin
            frag_w[8*(i-20) +: 8]   = b;
            arp_op_w[8*(i-20) +: 8] = b;
        end
        if (i == 23) proto = b;
        if (i >= 22 && i < 28) arp_sha[8*(i-22) +: 8] = b;
        if (i >= 26 && i < 30) ip_src[8*(i-26) +: 8] = b;
        if (i >= 28 && i < 32) arp_spa[8*(i-28) +: 8] = b;
        if (i >= 30 && i < 34) ip_dst[8*(i-30) +: 8] = b;
        if (i == 34) icmp_type = b;
        if (i == 36) udp_dport[15:8] = b;
        if (i == 37) udp_dport[7:0] = b;
        if (i >= 38 && i < 42) arp_tpa[8*(i-38) +: 8] = b;
        if (i == 38) udp_len[15:8] = b;
        if (i == 39) udp_len[7:0] = b;
        // index saturates on long frames
        if (byte_idx < MAX_FRAME) byte_idx = byte_idx + 11'd1;
        if (last) begin
            judge_frame(int'(i) + 1, v, code, slot);
            rec.verdict      = v;
            rec.unreach_code = (v == VERDICT_UNREACH) ? code : UNR_NONE;
            rec.port_slot    = (v == VERDICT_UDP) ? slot : 2'd0;
            rec.peer_mac     = (v == VERDICT_ARP_REQ || v == VERDICT_ARP_REP) ? arp_sha : eth_src;
            rec.peer_ip      = (v == VERDICT_ARP_REQ || v == VERDICT_ARP_REP) ? arp_spa :
                               (v >= VERDICT_ECHO) ? ip_src : 32'd0;
            rec.ip_total_len = (v >= VERDICT_ECHO) ? tot_len : 16'd0;
            expected_verdicts.push_back(rec);
            // per-frame state is cleared after every verdict
            byte_idx = '0;  eth_type_w = '0; eth_src = '0;   arp_op_w = '0;
            arp_sha = '0;   arp_spa = '0;    arp_tpa = '0;   ver_ihl = '0;
            tot_len = '0;   frag_w = '0;     proto = '0;     ip_src = '0;
            ip_dst = '0;    hdr_sum = '0;    icmp_type = '0; udp_dport = '0;
            udp_len = '0;
        end
    endtask

    // build one frame in frame_buf and queue its bytes for the driver
    task automatic build_frame(input t_frame_kind kind, input int unsigned flaws,
                               input int fixed_len, input int slot_pick);
        int          need;
        int          k;
        logic [3:0]  nib;
        logic [15:0] tot;
        logic [15:0] dport;
        logic [15:0] ulen;
        logic [31:0] dst;
        logic [19:0] acc;
        logic [16:0] fold;
        logic [15:0] csum;
        for (k = 0; k < 64; k++) frame_buf[k] = 8'($urandom);
        need = 34;
        case (kind)
            FR_ARP_REQ, FR_ARP_REP, FR_ARP_OTHER: begin
                frame_buf[12] = 8'h08;
                frame_buf[13] = 8'h06;
                frame_buf[20] = 8'h00;
                frame_buf[21] = (kind == FR_ARP_REQ) ? 8'h01 :
                                (kind == FR_ARP_REP) ? 8'h02 : 8'($urandom_range(3, 255));
                if (kind == FR_ARP_OTHER && $urandom_range(0, 1)) frame_buf[20] = 8'($urandom);
                if (!(flaws & FL_DST_OTHER)) begin
                    for (k = 0; k < 4; k++) begin
                        if (kind == FR_ARP_REQ) frame_buf[38+k] = cfg_own_ip[8*k +: 8];
                        if (kind == FR_ARP_REP) frame_buf[28+k] = cfg_query_ip[8*k +: 8];
                    end
                end
                need = 42;
            end
            FR_NOISE: begin
                // half of the noise carries a known ethertype over garbage
                if ($urandom_range(0, 1)) begin
                    frame_buf[12] = 8'h08;
                    frame_buf[13] = $urandom_range(0, 1) ? 8'h06 : 8'h00;
                end
                need = $urandom_range(1, 70);
            end
            default: begin
                frame_buf[12] = 8'h08;
                frame_buf[13] = 8'h00;
                frame_buf[14] = 8'h45;
                if (flaws & FL_VERSION) begin
                    nib = 4'($urandom_range(0, 14));
                    if (nib >= 4'd4) nib = nib + 4'd1;
                    frame_buf[14][7:4] = nib;
                end
                if (flaws & FL_IHL) begin
                    nib = 4'($urandom_range(0, 14));
                    if (nib >= 4'd5) nib = nib + 4'd1;
                    frame_buf[14][3:0] = nib;
                end
                tot = (flaws & FL_SHORTLEN) ? 16'($urandom_range(0, 19)) :
                                              16'($urandom_range(28, 600));
                frame_buf[16] = tot[15:8];
                frame_buf[17] = tot[7:0];
                // only the don't-fragment bit is allowed
                frame_buf[20] = $urandom_range(0, 1) ? 8'h40 : 8'h00;
                frame_buf[21] = 8'h00;
                if (flaws & FL_FRAG) begin
                    frame_buf[20] = 8'($urandom);
                    frame_buf[21] = 8'($urandom);
                    if (({frame_buf[21], frame_buf[20]} & FRAG_MASK) == 16'd0)
                        frame_buf[21] = 8'h01;
                end
                case (kind)
                    FR_ICMP: frame_buf[23] = PROTO_ICMP;
                    FR_UDP:  frame_buf[23] = PROTO_UDP;
                    default: begin
                        frame_buf[23] = 8'($urandom);
                        if (frame_buf[23] == PROTO_ICMP || frame_buf[23] == PROTO_UDP)
                            frame_buf[23] = frame_buf[23] + 8'd1;
                    end
                endcase
                dst = (flaws & FL_DST_BCAST) ? IP_BROADCAST :
                      (flaws & FL_DST_OTHER) ? 32'($urandom) : cfg_own_ip;
                for (k = 0; k < 4; k++) frame_buf[30+k] = dst[8*k +: 8];
                // header checksum over bytes 14..33, first byte of a pair low
                frame_buf[24] = 8'h00;
                frame_buf[25] = 8'h00;
                acc = '0;
                for (k = 14; k < 34; k += 2)
                    acc = acc + 20'({frame_buf[k+1], frame_buf[k]});
                fold = {1'b0, acc[15:0]} + 17'(acc[19:16]);
                fold = fold + 17'(fold[16]);
                csum = ~fold[15:0];
                frame_buf[24] = csum[7:0];
                frame_buf[25] = csum[15:8];
                if (flaws & FL_CSUM) frame_buf[24] = frame_buf[24] ^ 8'($urandom_range(1, 255));
                if (kind == FR_ICMP) begin
                    frame_buf[34] = ICMP_ECHO_REQ;
                    if (flaws & FL_ICMP_TYPE) frame_buf[34] = 8'($urandom_range(9, 263));
                    need = 35;
                end
                if (kind == FR_UDP) begin
                    if (flaws & FL_NOPORT) begin
                        dport = 16'($urandom);
                    end else begin
                        k     = (slot_pick < 0) ? $urandom_range(0, 3) : slot_pick;
                        dport = cfg_port[k];
                        if (dport == 16'd0) dport = 16'($urandom);
                    end
                    if (tot < IP_HDR_LEN)
                        ulen = 16'($urandom);
                    else if (flaws & FL_UDPLEN)
                        ulen = tot - IP_HDR_LEN + 16'($urandom_range(1, 100));
                    else
                        ulen = 16'($urandom_range(0, tot - IP_HDR_LEN));
                    frame_buf[36] = dport[15:8];
                    frame_buf[37] = dport[7:0];
                    frame_buf[38] = ulen[15:8];
                    frame_buf[39] = ulen[7:0];
                    need = 40;
                end
            end
        endcase
        if (fixed_len > 0)
            frame_len = fixed_len;
        else if (flaws & FL_TRUNC)
            frame_len = (need > 1) ? $urandom_range(1, need - 1) : 1;
        else if (flaws & FL_LONG)
            frame_len = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 8);
        else
            frame_len = need + $urandom_range(0, 6);
        for (k = 64; k < frame_len; k++) frame_buf[k] = 8'($urandom);
        for (k = 0; k < frame_len; k++)
            rx_bytes_pending.push_back(t_rx_beat'{data: frame_buf[k], last: k == frame_len - 1});
    endtask

    // apb write: setup cycle, then access cycle; register taken at the edge ending the access cycle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_OWN_IP:   cfg_own_ip   = value;
            CFG_QUERY_IP: cfg_query_ip = value;
            CFG_QUERY_ON: cfg_query_on = value[0];
            default:      cfg_port[2'(idx - CFG_PORT_A)] = value[15:0];
        endcase
    endtask

    // program all registers; 1 and 2 are the corner settings, 0 and 3 random
    task automatic apply_setting(input int which);
        logic [31:0] own;
        logic [31:0] qry;
        logic        qon;
        logic [15:0] pt [0:NUM_PORT_REGS-1];
        case (which)
            1: begin
                own = '0;
                qry = '1;
                qon = 1'b0;
                pt  = '{default: 16'h0000};
            end
            2: begin
                own = '1;
                qry = '0;
                qon = 1'b1;
                // duplicate port checks that the lower slot wins
                pt  = '{16'hffff, 16'h0001, 16'hffff, 16'h0000};
            end
            default: begin
                own = 32'($urandom);
                qry = 32'($urandom);
                qon = (which == 0) ? 1'b1 : 1'($urandom_range(0, 1));
                for (int k = 0; k < NUM_PORT_REGS; k++) pt[k] = 16'($urandom_range(1, 65535));
                if (which == 3) pt[2'($urandom_range(0, NUM_PORT_REGS - 1))] = 16'h0000;
            end
        endcase
        cfg_write(CFG_OWN_IP, own);
        cfg_write(CFG_QUERY_IP, qry);
        cfg_write(CFG_QUERY_ON, 32'(qon));
        for (int k = 0; k < NUM_PORT_REGS; k++)
            cfg_write(CFG_IDX_W'(int'(CFG_PORT_A) + k), 32'(pt[k]));
    endtask

    // hold the sender until every queued byte went in and every verdict came out
    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (rx_bytes_pending.size() != 0 || rx_ch.valid || expected_verdicts.size() != 0);
        // let the pipeline settle before touching registers
        repeat (10) @(negedge i_clk);
    endtask

    // byte driver and result back-pressure, both updated on the falling edge
    always @(negedge i_clk) begin : rx_driver
        t_rx_beat beat;
        if (i_rst_n) begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            // a byte on the wire stays put until its transfer happens
            if (!rx_ch.valid || rx_took) begin
                if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat = rx_bytes_pending.pop_front();
                    rx_ch.valid      <= 1'b1;
                    rx_ch.frame_byte <= beat.data;
                    rx_ch.last_byte  <= beat.last;
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on each byte transfer, check on each result transfer
    always @(posedge i_clk) begin : rx_res_monitor
        t_verdict_rec want;
        bit           res_took;
        rx_took  = rx_ch.valid && rx_ch.ready && i_rst_n;
        res_took = res_ch.valid && res_ch.ready && i_rst_n;
        if (rx_took) track_frame_byte(rx_ch.frame_byte, rx_ch.last_byte);
        if (res_took) begin
            if (expected_verdicts.size() == 0) begin
                $error("verdict %0d arrived with no frame outstanding", res_ch.verdict);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                if (res_ch.verdict !== want.verdict) begin
                    $error("verdict expected %0d got %0d", want.verdict, res_ch.verdict);
                    mismatches++;
                end
                if (res_ch.unreach_code !== want.unreach_code) begin
                    $error("unreach_code expected %0d got %0d", want.unreach_code,
                           res_ch.unreach_code);
                    mismatches++;
                end
                if (res_ch.port_slot !== want.port_slot) begin
                    $error("port_slot expected %0d got %0d", want.port_slot, res_ch.port_slot);
                    mismatches++;
                end
                if (res_ch.peer_mac !== want.peer_mac) begin
                    $error("peer_mac expected %h got %h", want.peer_mac, res_ch.peer_mac);
                    mismatches++;
                end
                if (res_ch.peer_ip !== want.peer_ip) begin
                    $error("peer_ip expected %h got %h", want.peer_ip, res_ch.peer_ip);
                    mismatches++;
                end
                if (res_ch.ip_total_len !== want.ip_total_len) begin
                    $error("ip_total_len expected %0d got %0d", want.ip_total_len,
                           res_ch.ip_total_len);
                    mismatches++;
                end
            end
        end
        // watchdog on cycles without any transfer
        if (i_rst_n) begin
            stall_cycles = (rx_took || res_took) ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int seg_bytes;
        int seg_frames;
        int r;
        int unsigned flaws;
        t_frame_kind kind;

        // every input known from time zero
        rx_ch.valid      = 1'b0;
        rx_ch.frame_byte = 8'h00;
        rx_ch.last_byte  = 1'b0;
        res_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_rst_n          = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames: sender idles 29%, receiver 70%
        send_idle_pct = 29;
        recv_idle_pct = 70;
        apply_setting(0);
        build_frame(FR_ARP_REQ, 0, 0, 0);
        build_frame(FR_ARP_REP, 0, 0, 0);
        build_frame(FR_ARP_OTHER, 0, 0, 0);
        build_frame(FR_ARP_REQ, 0, 41, 0);              // arp one byte short
        build_frame(FR_ARP_REQ, FL_DST_OTHER, 0, 0);    // request for someone else
        build_frame(FR_ICMP, 0, 0, 0);
        build_frame(FR_ICMP, FL_ICMP_TYPE, 0, 0);
        build_frame(FR_ICMP, 0, 34, 0);                 // ends before the icmp type
        build_frame(FR_ICMP, FL_DST_BCAST, 0, 0);       // echo to broadcast still answers
        for (int s = 0; s < NUM_PORT_REGS; s++) build_frame(FR_UDP, 0, 0, s);
        build_frame(FR_UDP, FL_NOPORT, 0, 0);           // port unreachable
        build_frame(FR_UDP, FL_NOPORT | FL_DST_BCAST, 0, 0);
        build_frame(FR_UDP, FL_UDPLEN, 0, 0);           // udp length past ip payload
        build_frame(FR_UDP, FL_SHORTLEN, 0, 0);         // total length below header size
        build_frame(FR_UDP, 0, 39, 0);                  // ends inside the udp header
        build_frame(FR_OTHER_PROTO, 0, 0, 0);           // protocol unreachable
        build_frame(FR_ICMP, FL_IHL, 0, 0);             // header length other than five words
        build_frame(FR_ICMP, FL_FRAG, 0, 0);            // fragment
        build_frame(FR_ICMP, FL_CSUM, 0, 0);
        build_frame(FR_ICMP, FL_VERSION, 0, 0);
        build_frame(FR_ICMP, FL_DST_OTHER, 0, 0);
        build_frame(FR_OTHER_PROTO, 0, 33, 0);          // ends inside the ip header
        build_frame(FR_NOISE, 0, 1, 0);                 // single byte frame
        build_frame(FR_ICMP, FL_LONG, 0, 0);            // index saturates
        wait_for_idle();

        // random segments; sides swapped for two segments, then no idling
        for (int seg = 0; seg < 3; seg++) begin
            send_idle_pct = (seg < 2) ? 70 : 0;
            recv_idle_pct = (seg < 2) ? 29 : 0;
            apply_setting(seg + 1);
            seg_bytes  = 0;
            seg_frames = 0;
            while (seg_bytes < 40 || seg_frames < 2) begin
                r    = $urandom_range(0, 99);
                kind = (r < 12) ? FR_ARP_REQ : (r < 22) ? FR_ARP_REP :
                       (r < 27) ? FR_ARP_OTHER : (r < 45) ? FR_ICMP :
                       (r < 80) ? FR_UDP : (r < 90) ? FR_OTHER_PROTO : FR_NOISE;
                // mostly well-formed frames, some with one or two flaws
                r     = $urandom_range(0, 99);
                flaws = 0;
                if (r >= 55) flaws = 1 << $urandom_range(0, NUM_RAND_FLAWS - 1);
                if (r >= 90) flaws = flaws | (1 << $urandom_range(0, NUM_RAND_FLAWS - 1));
                build_frame(kind, flaws, 0, -1);
                seg_bytes += frame_len;
                seg_frames++;
            end
            wait_for_idle();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/efc_pkg.sv
rtl/efc_rx_if.sv
rtl/efc_res_if.sv
rtl/ethernet_ipv4_arp_frame_classifier_core.sv
rtl/efc_checker.sv
verif/testbench.sv
